// ===== sv/two_moduli_residue_alu_top_defines.svh =====
// Assertion helpers used by the RTL sequencer (tmra_ctrl)
`ifndef TWO_MODULI_RESIDUE_ALU_TOP_DEFINES_SVH
`define TWO_MODULI_RESIDUE_ALU_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== sv/tmra_pkg.sv =====
`default_nettype none
package tmra_pkg;

    localparam int VALUE_BITS = 8;
    localparam logic [15:0] MAXV = 16'((32'd1 << VALUE_BITS) - 1);

    // function codes
    localparam logic [3:0] F_ENC  = 4'd0;
    localparam logic [3:0] F_DEC  = 4'd1;
    localparam logic [3:0] F_ADD  = 4'd2;
    localparam logic [3:0] F_SUB  = 4'd3;
    localparam logic [3:0] F_MUL  = 4'd4;
    localparam logic [3:0] F_EQ   = 4'd5;
    localparam logic [3:0] F_LT   = 4'd6;
    localparam logic [3:0] F_DIV  = 4'd7;
    localparam logic [3:0] F_MOD  = 4'd8;
    localparam logic [3:0] F_XOR  = 4'd9;
    localparam logic [3:0] F_SHR  = 4'd10;

    // configuration register indexes
    localparam logic [1:0] CFG_M1  = 2'd0;
    localparam logic [1:0] CFG_M2  = 2'd1;
    localparam logic [1:0] CFG_INV = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE, S_DEC1, S_DEC2, S_DEC3, S_DEC4, S_DEC5, S_DEC6,
        S_SHD, S_PROD, S_FUNC, S_OUT1, S_OUT2, S_EMIT
    } t_state;

    typedef enum logic [3:0] {
        STP_NONE, STP_LOAD, STP_DEC1, STP_DEC2, STP_DEC3, STP_DEC4, STP_DEC5,
        STP_DEC6, STP_SHD, STP_PROD, STP_FUNC, STP_OUT1, STP_OUT2
    } t_step;

    typedef struct packed {
        t_step step;
        logic  opb;
        logic  div_start;
        logic  capture;
    } t_cmd;

endpackage
`default_nettype wire

// ===== sv/two_moduli_residue_alu_top.sv =====
// The shared 32-step restoring divider runs twelve reductions per item; start is
// not taken while busy, and is taken again the cycle after the result strobe.
// Reset: synchronous active-low i_rst_n returns the sequencer to idle and the
// moduli and inverse to 23, 29 and 24. The receiver cannot stall the result.
`default_nettype none
module two_moduli_residue_alu_top (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_start,
    output logic        o_busy,
    input  wire  [3:0]  i_func,
    input  wire  [7:0]  i_a_mod_first,
    input  wire  [7:0]  i_a_mod_second,
    input  wire  [7:0]  i_b_mod_first,
    input  wire  [7:0]  i_b_mod_second,
    input  wire  [7:0]  i_plain_in,
    input  wire  [2:0]  i_shift_amount,
    output logic        o_res_valid,
    output logic [7:0]  o_res_mod_first,
    output logic [7:0]  o_res_mod_second,
    output logic [15:0] o_plain_out,
    output logic        o_flag,
    output logic        o_error,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [1:0]  i_cfg_index,
    input  wire  [7:0]  i_cfg_data
);
    import tmra_pkg::*;

    t_cmd cmd;
    logic div_done;

    assign o_cfg_ready = 1'b1;

    tmra_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_div_done  (div_done),
        .o_cmd       (cmd),
        .o_busy      (o_busy),
        .o_res_valid (o_res_valid)
    );

    tmra_datapath u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_div_done       (div_done),
        .i_cfg_we         (i_cfg_valid & o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_func           (i_func),
        .i_a_mod_first    (i_a_mod_first),
        .i_a_mod_second   (i_a_mod_second),
        .i_b_mod_first    (i_b_mod_first),
        .i_b_mod_second   (i_b_mod_second),
        .i_plain_in       (i_plain_in),
        .i_shift_amount   (i_shift_amount),
        .o_res_mod_first  (o_res_mod_first),
        .o_res_mod_second (o_res_mod_second),
        .o_plain_out      (o_plain_out),
        .o_flag           (o_flag),
        .o_error          (o_error)
    );
endmodule
`default_nettype wire

// ===== sv/tmra_divider.sv =====
`default_nettype none
module tmra_divider (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_start,
    input  wire  [31:0] i_dividend,
    input  wire  [15:0] i_divisor,
    output logic        o_done,
    output logic [31:0] o_quot,
    output logic [15:0] o_rem
);
    logic [31:0] r_quot;
    logic [15:0] r_rem, r_div;
    logic [4:0]  r_cnt;
    logic        r_run, r_done;
    logic [16:0] trial;
    logic        fits;

    // one restoring step
    always_comb begin
        trial = {r_rem, r_quot[31]};
        fits  = trial >= {1'b0, r_div};
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_div  <= i_divisor;
        end else if (r_run) begin
            r_quot <= {r_quot[30:0], fits};
            r_rem  <= fits ? 16'(trial - {1'b0, r_div}) : trial[15:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;
endmodule
`default_nettype wire

// ===== sv/tmra_ctrl.sv =====
`default_nettype none
`include "two_moduli_residue_alu_top_defines.svh"
module tmra_ctrl (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_start,
    input  wire          i_div_done,
    output tmra_pkg::t_cmd o_cmd,
    output logic         o_busy,
    output logic         o_res_valid
);
    import tmra_pkg::*;

    t_state r_state, n_state;
    logic   r_opb, n_opb;
    logic   r_issued, n_issued;
    logic   is_div;

    // outputs per state
    always_comb begin
        is_div = r_state inside {S_DEC1, S_DEC2, S_DEC3, S_DEC5, S_SHD, S_FUNC,
                                 S_OUT1, S_OUT2};
        o_cmd.opb       = r_opb;
        o_cmd.div_start = is_div && !r_issued;
        o_cmd.capture   = is_div ? i_div_done : (r_state inside {S_DEC4, S_DEC6, S_PROD});
        case (r_state)
            S_IDLE: begin
                o_cmd.step    = STP_LOAD;
                o_cmd.capture = i_start;
            end
            S_DEC1:  o_cmd.step = STP_DEC1;
            S_DEC2:  o_cmd.step = STP_DEC2;
            S_DEC3:  o_cmd.step = STP_DEC3;
            S_DEC4:  o_cmd.step = STP_DEC4;
            S_DEC5:  o_cmd.step = STP_DEC5;
            S_DEC6:  o_cmd.step = STP_DEC6;
            S_SHD:   o_cmd.step = STP_SHD;
            S_PROD:  o_cmd.step = STP_PROD;
            S_FUNC:  o_cmd.step = STP_FUNC;
            S_OUT1:  o_cmd.step = STP_OUT1;
            S_OUT2:  o_cmd.step = STP_OUT2;
            default: o_cmd.step = STP_NONE;
        endcase
        o_busy      = r_state != S_IDLE;
        o_res_valid = r_state == S_EMIT;
    end

    // next state
    always_comb begin
        n_state  = r_state;
        n_opb    = r_opb;
        n_issued = o_cmd.div_start ? 1'b1 : r_issued;
        if (o_cmd.capture) begin
            n_issued = 1'b0;
            case (r_state)
                S_IDLE: begin
                    n_state = S_DEC1;
                    n_opb   = 1'b0;
                end
                S_DEC1: n_state = S_DEC2;
                S_DEC2: n_state = S_DEC3;
                S_DEC3: n_state = S_DEC4;
                S_DEC4: n_state = S_DEC5;
                S_DEC5: n_state = S_DEC6;
                S_DEC6: begin
                    n_state = r_opb ? S_SHD : S_DEC1;
                    n_opb   = 1'b1;
                end
                S_SHD:   n_state = S_PROD;
                S_PROD:  n_state = S_FUNC;
                S_FUNC:  n_state = S_OUT1;
                S_OUT1:  n_state = S_OUT2;
                S_OUT2:  n_state = S_EMIT;
                default: n_state = S_IDLE;
            endcase
        end else if (r_state == S_EMIT) begin
            n_state = S_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_opb    <= 1'b0;
            r_issued <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_opb    <= n_opb;
            r_issued <= n_issued;
        end
    end

    `ASSERT_NEXT(a_strobe_then_idle, o_res_valid, !o_busy)
    `ASSERT_NEXT(a_accept_then_busy, i_start && !o_busy, o_busy)
    `ASSERT_NEXT(a_no_early_done, o_cmd.div_start, !i_div_done)
endmodule
`default_nettype wire

// ===== sv/tmra_datapath.sv =====
`default_nettype none
module tmra_datapath (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  tmra_pkg::t_cmd i_cmd,
    output logic         o_div_done,
    input  wire          i_cfg_we,
    input  wire  [1:0]   i_cfg_index,
    input  wire  [7:0]   i_cfg_data,
    input  wire  [3:0]   i_func,
    input  wire  [7:0]   i_a_mod_first,
    input  wire  [7:0]   i_a_mod_second,
    input  wire  [7:0]   i_b_mod_first,
    input  wire  [7:0]   i_b_mod_second,
    input  wire  [7:0]   i_plain_in,
    input  wire  [2:0]   i_shift_amount,
    output logic [7:0]   o_res_mod_first,
    output logic [7:0]   o_res_mod_second,
    output logic [15:0]  o_plain_out,
    output logic         o_flag,
    output logic         o_error
);
    import tmra_pkg::*;

    // configuration registers
    logic [7:0]  r_cfg_m1, r_cfg_m2, r_cfg_inv;
    // item registers
    logic [3:0]  r_func;
    logic [7:0]  r_a1, r_a2, r_b1, r_b2, r_plain;
    logic [2:0]  r_n;
    logic [7:0]  r_m1, r_m2, r_inv;
    logic [15:0] r_mm;
    logic [7:0]  r_v1, r_t, r_d, r_v2;
    logic [31:0] r_p;
    logic [15:0] r_a, r_b, r_bs, r_val, r_pout;
    logic        r_flag, r_err;
    logic [7:0]  r_res1, r_res2;

    logic [31:0] dvd, quot;
    logic [15:0] dvs, rem;
    logic [7:0]  op1, op2;
    logic [8:0]  dsum;
    logic [16:0] ssum, sdif;
    logic [15:0] nval, npout, ndiv;
    logic        nflag, nerr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_m1  <= 8'd23;
            r_cfg_m2  <= 8'd29;
            r_cfg_inv <= 8'd24;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_M1:  r_cfg_m1  <= i_cfg_data;
                CFG_M2:  r_cfg_m2  <= i_cfg_data;
                CFG_INV: r_cfg_inv <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // divider operand selection
    always_comb begin
        op1 = i_cmd.opb ? r_b1 : r_a1;
        op2 = i_cmd.opb ? r_b2 : r_a2;
        dvd = '0;
        dvs = 16'd1;
        case (i_cmd.step)
            STP_DEC1: begin dvd = {24'd0, op1}; dvs = {8'd0, r_m1}; end
            STP_DEC2: begin dvd = {24'd0, op2}; dvs = {8'd0, r_m2}; end
            STP_DEC3: begin dvd = {24'd0, r_v1}; dvs = {8'd0, r_m2}; end
            STP_DEC5: begin dvd = r_p; dvs = {8'd0, r_m2}; end
            STP_SHD:  begin dvd = 32'd1 << r_n; dvs = r_mm; end
            STP_FUNC: begin
                case (r_func)
                    F_MUL:        begin dvd = r_p; dvs = r_mm; end
                    F_DIV, F_MOD: begin dvd = {16'd0, r_a}; dvs = r_b; end
                    F_SHR:        begin dvd = {16'd0, r_a}; dvs = r_bs; end
                    default:      ;
                endcase
            end
            STP_OUT1: begin dvd = {16'd0, r_val}; dvs = {8'd0, r_m1}; end
            STP_OUT2: begin dvd = {16'd0, r_val}; dvs = {8'd0, r_m2}; end
            default:  ;
        endcase
    end

    tmra_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (dvd),
        .i_divisor  (dvs),
        .o_done     (o_div_done),
        .o_quot     (quot),
        .o_rem      (rem)
    );

    // second mixed-radix digit difference, reduced mod m2
    always_comb begin
        dsum = 9'({1'b0, r_t} + {1'b0, r_m2} - {1'b0, rem[7:0]});
        if (dsum >= {1'b0, r_m2})
            dsum = 9'(dsum - {1'b0, r_m2});
    end

    // divide helper, divisor in ndiv
    always_comb begin
        ndiv = (r_func == F_SHR) ? r_bs : r_b;
    end

    // function result
    always_comb begin
        nval  = '0;
        npout = '0;
        nflag = 1'b0;
        nerr  = 1'b0;
        ssum  = {1'b0, r_a} + {1'b0, r_b};
        if (ssum >= {1'b0, r_mm})
            ssum = 17'(ssum - {1'b0, r_mm});
        sdif  = 17'({1'b0, r_a} + {1'b0, r_mm} - {1'b0, r_b});
        if (sdif >= {1'b0, r_mm})
            sdif = 17'(sdif - {1'b0, r_mm});
        case (r_func)
            F_ENC: nval = {8'd0, r_plain};
            F_DEC: begin
                nval  = r_a;
                npout = r_a;
            end
            F_ADD: begin
                nval  = ssum[15:0] & MAXV;
                nflag = (nval < r_a) || (nval < r_b);
            end
            F_SUB: nval = sdif[15:0];
            F_MUL: nval = rem;
            F_EQ:  nflag = r_a == r_b;
            F_LT:  nflag = r_a < r_b;
            F_MOD: begin
                if (r_b == 16'd0) nerr = 1'b1;
                else              nval = rem;
            end
            F_XOR: begin
                if (r_a == r_b)        nval = '0;
                else if (r_b == 16'd0) nval = r_a;
                else if (r_a == 16'd0) nval = r_b;
                else                   nval = (r_a ^ r_b) & MAXV;
            end
            F_DIV, F_SHR: begin
                if (r_func == F_SHR && r_n == 3'd0) nval = r_a;
                else if (ndiv == 16'd0)             nerr = 1'b1;
                else if (r_a == ndiv)               nval = 16'd1;
                else if (r_a < ndiv)                nval = '0;
                else if (ndiv == 16'd1)             nval = r_a;
                else                                nval = quot[15:0] & MAXV;
            end
            default: ;
        endcase
    end

    // step captures
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            case (i_cmd.step)
                STP_LOAD: begin
                    r_func  <= i_func;
                    r_a1    <= i_a_mod_first;
                    r_a2    <= i_a_mod_second;
                    r_b1    <= i_b_mod_first;
                    r_b2    <= i_b_mod_second;
                    r_plain <= i_plain_in;
                    r_n     <= i_shift_amount;
                    r_m1    <= (r_cfg_m1 == 8'd0) ? 8'd1 : r_cfg_m1;
                    r_m2    <= (r_cfg_m2 == 8'd0) ? 8'd1 : r_cfg_m2;
                    r_inv   <= r_cfg_inv;
                    r_mm    <= ((r_cfg_m1 == 8'd0) ? 8'd1 : r_cfg_m1)
                             * ((r_cfg_m2 == 8'd0) ? 8'd1 : r_cfg_m2);
                end
                STP_DEC1: r_v1 <= rem[7:0];
                STP_DEC2: r_t  <= rem[7:0];
                STP_DEC3: r_d  <= dsum[7:0];
                // full 16-bit product of digit and inverse
                STP_DEC4: r_p  <= {16'd0, 16'(r_d) * 16'(r_inv)};
                STP_DEC5: r_v2 <= rem[7:0];
                STP_DEC6: begin
                    if (i_cmd.opb) r_b <= 16'({8'd0, r_v1} + r_v2 * r_m1);
                    else           r_a <= 16'({8'd0, r_v1} + r_v2 * r_m1);
                end
                STP_SHD:  r_bs <= rem;
                STP_PROD: r_p  <= r_a * r_b;
                STP_FUNC: begin
                    r_val  <= nval;
                    r_pout <= npout;
                    r_flag <= nflag;
                    r_err  <= nerr;
                end
                STP_OUT1: r_res1 <= rem[7:0];
                STP_OUT2: r_res2 <= rem[7:0];
                default:  ;
            endcase
        end
    end

    assign o_res_mod_first  = r_res1;
    assign o_res_mod_second = r_res2;
    assign o_plain_out      = r_pout;
    assign o_flag           = r_flag;
    assign o_error          = r_err;
endmodule
`default_nettype wire
